// File: rtl/core/qws_pkg.sv
// Package for the quoted word splitter: widths, character codes, result kinds
// and the structs passed between the decoder, the result queue and the top level.
// No dependencies.
`timescale 1ns / 1ps

package qws_pkg;

   localparam int ByteW      = 8;
   localparam int MaxRsp     = 3;                    // most results caused by one byte
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);
   localparam int RspCntW    = $clog2(MaxRsp + 1);

   localparam logic [ByteW-1:0] ChSemi   = 8'h3B;
   localparam logic [ByteW-1:0] ChTab    = 8'h09;
   localparam logic [ByteW-1:0] ChSpace  = 8'h20;
   localparam logic [ByteW-1:0] ChDquote = 8'h22;
   localparam logic [ByteW-1:0] ChBslash = 8'h5C;

   typedef enum logic [2:0] {
      KIND_BYTE      = 3'd0,
      KIND_WORD_END  = 3'd1,
      KIND_CMD_END   = 3'd2,
      KIND_LINE_END  = 3'd3,
      KIND_QUOTE_ERR = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [ByteW-1:0]       data;
      logic                   last;
   } rsp_item_type;

   typedef struct packed {
      logic in_quote;
      logic word_open;
      logic escape_pending;
   } split_state_type;

   typedef struct packed {
      logic [RspCntW-1:0]             count;
      rsp_item_type [MaxRsp-1:0]      items;
   } decode_out_type;

endpackage

// File: rtl/core/quoted_word_splitter.sv
// Top level of the quoted word splitter: parser flags, per-byte decoder and
// result queue behind stream ports.
// Depends on qws_pkg, qws_decode and qws_rsp_queue.
//
//   channel | dir | tdata          | tuser     | tlast
//   req     | in  | byte_in [7:0]  | -         | line_final
//   rsp     | out | byte_out [7:0] | kind[2:0] | last
//
// A byte is decoded in the cycle of its transfer; its results are registered in the
// queue and offered on rsp in order, one result per cycle while rsp_tready is high.
// req_tready is high while the queue holds at most one result, so one byte is
// taken every cycle as long as each byte causes at most one result and rsp_tready
// stays high; a byte causing more results holds req_tready low until the queue is back to one.
// Synchronous reset clears the parser flags and empties the queue.
`timescale 1ns / 1ps

module quoted_word_splitter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [qws_pkg::ByteW-1:0] req_tdata,   // [7:0] byte_in
   input  logic                      req_tlast,   // line_final
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [qws_pkg::ByteW-1:0] rsp_tdata,   // [7:0] byte_out
   output logic [2:0]                rsp_tuser,   // [2:0] kind
   output logic                      rsp_tlast    // last
);

   qws_pkg::split_state_type       state_ff;
   qws_pkg::split_state_type       state_in;
   qws_pkg::split_state_type       state_dec;
   qws_pkg::decode_out_type        dec;
   qws_pkg::rsp_item_type          head;
   logic                           req_xfer;
   logic                           rsp_xfer;
   logic                           room;
   logic [qws_pkg::QueueCntW-1:0]  fill;

   assign req_tready = room;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   qws_decode u_decode (
      .state      (state_ff),
      .byte_in    (req_tdata),
      .line_final (req_tlast),
      .state_next (state_dec),
      .dec        (dec)
   );

   // hold the flags unless a byte transfers
   assign state_in = req_xfer ? state_dec : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   qws_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_xfer),
      .push_data  (dec),
      .pop        (rsp_xfer),
      .head       (head),
      .head_valid (rsp_tvalid),
      .room       (room),
      .fill       (fill)
   );

   assign rsp_tdata = head.data;
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   // queue never overfills
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= qws_pkg::QueueCntW'(qws_pkg::QueueDepth))
      else $error("result queue overfilled");

   // a line end always leaves a result to deliver
   a_line_end_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> rsp_tvalid)
      else $error("line end produced no result");

   // flags are clear after a line end
   a_line_end_clear: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> state_ff == '0)
      else $error("parser flags not cleared at line end");

   // only word bytes carry data
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != qws_pkg::KIND_BYTE) |-> rsp_tdata == '0)
      else $error("non-byte result carries data");

endmodule

// File: rtl/core/qws_decode.sv
// Per-byte decoder of the quoted word splitter: from the parser flags and one
// byte it gives the next flags and up to three packed results.
// Depends on qws_pkg.
`timescale 1ns / 1ps

module qws_decode (
   input  qws_pkg::split_state_type state,
   input  logic [qws_pkg::ByteW-1:0] byte_in,
   input  logic                      line_final,
   output qws_pkg::split_state_type  state_next,
   output qws_pkg::decode_out_type   dec
);

   localparam int NumCand       = 5;
   localparam int RspCntW_Local = $clog2(NumCand + 1);

   logic                     is_space;
   logic                     is_semi;
   logic                     is_quote;
   logic                     is_bslash;
   qws_pkg::split_state_type mid;
   qws_pkg::rsp_item_type    cand [NumCand];
   logic [NumCand-1:0]       cand_valid;

   // classify the byte
   always_comb begin
      is_space  = (byte_in == qws_pkg::ChSpace) || (byte_in == qws_pkg::ChTab);
      is_semi   = (byte_in == qws_pkg::ChSemi);
      is_quote  = (byte_in == qws_pkg::ChDquote);
      is_bslash = (byte_in == qws_pkg::ChBslash);
   end

   // flag update for the byte itself, then line end clears everything
   always_comb begin
      mid = state;
      if (state.escape_pending) begin
         mid.escape_pending = 1'b0;
         mid.word_open      = 1'b1;
      end else if (is_space) begin
         if (!state.in_quote) mid.word_open = 1'b0;
      end else if (is_semi) begin
         if (!state.in_quote) mid = '0;
      end else if (is_quote) begin
         mid.in_quote  = !state.in_quote;
         mid.word_open = 1'b1;
      end else if (is_bslash) begin
         mid.escape_pending = 1'b1;
      end else begin
         mid.word_open = 1'b1;
      end
      state_next = line_final ? '0 : mid;
   end

   // candidate results in stream order; at most three are valid at once
   always_comb begin
      cand[0] = '{kind: qws_pkg::KIND_BYTE, data: byte_in, last: 1'b0};
      cand[1] = '{kind: qws_pkg::KIND_WORD_END, data: '0, last: 1'b0};
      cand[2] = '{kind: qws_pkg::KIND_CMD_END, data: '0, last: 1'b0};
      cand[3] = '{kind: (mid.in_quote ? qws_pkg::KIND_QUOTE_ERR : qws_pkg::KIND_WORD_END),
                  data: '0, last: 1'b0};
      cand[4] = '{kind: qws_pkg::KIND_LINE_END, data: '0, last: 1'b0};

      cand_valid[0] = state.escape_pending
                    || (!is_space && !is_semi && !is_quote && !is_bslash)
                    || ((is_space || is_semi) && state.in_quote);
      cand_valid[1] = !state.escape_pending && (is_space || is_semi)
                    && !state.in_quote && state.word_open;
      cand_valid[2] = !state.escape_pending && is_semi && !state.in_quote;
      cand_valid[3] = line_final && (mid.in_quote || mid.word_open);
      cand_valid[4] = line_final;
   end

   // pack valid candidates into the result slots and mark the final one
   always_comb begin
      logic [RspCntW_Local-1:0] idx;
      idx = '0;
      dec = '0;
      for (int i = 0; i < NumCand; i++) begin
         if (cand_valid[i]) begin
            if (idx < RspCntW_Local'(qws_pkg::MaxRsp)) begin
               dec.items[idx[qws_pkg::RspCntW-1:0]] = cand[i];
            end
            idx = idx + 1'b1;
         end
      end
      dec.count = idx[qws_pkg::RspCntW-1:0];
      for (int k = 0; k < qws_pkg::MaxRsp; k++) begin
         dec.items[k].last = (dec.count == qws_pkg::RspCntW'(k + 1));
      end
   end

endmodule

// File: rtl/core/qws_rsp_queue.sv
// Result queue of the quoted word splitter: takes a burst of up to three
// results in one cycle and hands them out one transfer per cycle while pop is high.
// Depends on qws_pkg.
`timescale 1ns / 1ps

module qws_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  qws_pkg::decode_out_type push_data,
   input  logic                    pop,
   output qws_pkg::rsp_item_type   head,
   output logic                    head_valid,
   output logic                    room,
   output logic [qws_pkg::QueueCntW-1:0] fill
);

   qws_pkg::rsp_item_type               mem_ff [qws_pkg::QueueDepth];
   logic [qws_pkg::QueuePtrW-1:0]       head_ff;
   logic [qws_pkg::QueuePtrW-1:0]       head_in;
   logic [qws_pkg::QueueCntW-1:0]       cnt_ff;
   logic [qws_pkg::QueueCntW-1:0]       cnt_in;
   logic [qws_pkg::QueuePtrW-1:0]       tail;
   logic [qws_pkg::QueueCntW-1:0]       push_n;

   // room for a full burst behind what is held
   assign room       = (cnt_ff <= qws_pkg::QueueCntW'(qws_pkg::QueueDepth - qws_pkg::MaxRsp));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[head_ff];
   assign fill       = cnt_ff;
   assign tail       = head_ff + cnt_ff[qws_pkg::QueuePtrW-1:0];

   // advance pointers and fill count
   always_comb begin
      push_n  = push ? qws_pkg::QueueCntW'(push_data.count) : '0;
      head_in = pop ? head_ff + 1'b1 : head_ff;
      cnt_in  = cnt_ff + push_n - qws_pkg::QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

   // append the burst behind the current tail
   always_ff @(posedge clock) begin
      for (int k = 0; k < qws_pkg::MaxRsp; k++) begin
         if (push && (qws_pkg::RspCntW'(k) < push_data.count)) begin
            mem_ff[tail + qws_pkg::QueuePtrW'(k)] <= push_data.items[k];
         end
      end
   end

endmodule

// File: tb/quoted_word_splitter_tb.sv
// Testbench for quoted_word_splitter: drives command-line bytes on req, predicts
// the word/command/line results per byte and checks each rsp transfer in order.
// Depends on qws_pkg and the quoted_word_splitter RTL.
`timescale 1ns / 1ps

module quoted_word_splitter_tb;

   typedef struct {
      logic [qws_pkg::ByteW-1:0] ch;
      logic                      eol;
      bit                        drain;   // wait for all results before offering this byte
   } line_byte_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [qws_pkg::ByteW-1:0] req_tdata = '0;    // [7:0] byte_in
   logic                      req_tlast = 1'b0;  // line_final
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [qws_pkg::ByteW-1:0] rsp_tdata;         // [7:0] byte_out
   logic [2:0]                rsp_tuser;         // [2:0] kind
   logic                      rsp_tlast;         // last

   line_byte_type         line_bytes[$];
   qws_pkg::rsp_item_type expected_rsp[$];

   // predictor state
   bit quoting, in_word, escaped_next;

   int errors        = 0;
   int bytes_sent    = 0;
   int results_seen  = 0;
   int gap_left      = 0;
   int stall_left    = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   quoted_word_splitter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic qws_pkg::rsp_item_type rsp_of(qws_pkg::kind_type k,
                                                    logic [qws_pkg::ByteW-1:0] d);
      qws_pkg::rsp_item_type r;
      r.kind = k;
      r.data = d;
      r.last = 1'b0;
      return r;
   endfunction

   // Split one accepted byte and queue the results it causes
   function automatic void split_byte(logic [qws_pkg::ByteW-1:0] ch, logic eol);
      qws_pkg::rsp_item_type res [qws_pkg::MaxRsp];
      int n;
      n = 0;
      if (escaped_next) begin
         escaped_next = 1'b0;
         in_word = 1'b1;
         res[n] = rsp_of(qws_pkg::KIND_BYTE, ch);
         n++;
      end else if (ch == qws_pkg::ChSpace || ch == qws_pkg::ChTab) begin
         if (quoting) begin
            res[n] = rsp_of(qws_pkg::KIND_BYTE, ch);
            n++;
         end else if (in_word) begin
            in_word = 1'b0;
            res[n] = rsp_of(qws_pkg::KIND_WORD_END, '0);
            n++;
         end
      end else if (ch == qws_pkg::ChSemi) begin
         if (quoting) begin
            res[n] = rsp_of(qws_pkg::KIND_BYTE, ch);
            n++;
         end else begin
            if (in_word) begin
               res[n] = rsp_of(qws_pkg::KIND_WORD_END, '0);
               n++;
            end
            res[n] = rsp_of(qws_pkg::KIND_CMD_END, '0);
            n++;
            quoting = 1'b0;
            in_word = 1'b0;
            escaped_next = 1'b0;
         end
      end else if (ch == qws_pkg::ChDquote) begin
         quoting = !quoting;
         in_word = 1'b1;
      end else if (ch == qws_pkg::ChBslash) begin
         escaped_next = 1'b1;
      end else begin
         in_word = 1'b1;
         res[n] = rsp_of(qws_pkg::KIND_BYTE, ch);
         n++;
      end

      // close the line: error replaces the word end when a quote is open
      if (eol) begin
         if (quoting) begin
            res[n] = rsp_of(qws_pkg::KIND_QUOTE_ERR, '0);
            n++;
         end else if (in_word) begin
            res[n] = rsp_of(qws_pkg::KIND_WORD_END, '0);
            n++;
         end
         res[n] = rsp_of(qws_pkg::KIND_LINE_END, '0);
         n++;
         quoting = 1'b0;
         in_word = 1'b0;
         escaped_next = 1'b0;
      end

      for (int i = 0; i < n; i++) begin
         if (i == n - 1) res[i].last = 1'b1;
         expected_rsp.push_back(res[i]);
      end
   endfunction

   function automatic void add_byte(logic [qws_pkg::ByteW-1:0] ch, logic eol,
                                    bit drain = 1'b0);
      line_byte_type b;
      b.ch = ch;
      b.eol = eol;
      b.drain = drain;
      line_bytes.push_back(b);
   endfunction

   // Mostly special characters, otherwise any byte
   function automatic logic [qws_pkg::ByteW-1:0] any_char();
      case ($urandom_range(0, 9))
         0: return qws_pkg::ChSpace;
         1: return qws_pkg::ChTab;
         2: return qws_pkg::ChSemi;
         3: return qws_pkg::ChDquote;
         4: return qws_pkg::ChBslash;
         default: return qws_pkg::ByteW'($urandom_range(0, 255));
      endcase
   endfunction

   // Ordinary word character: any byte that is not a delimiter
   function automatic logic [qws_pkg::ByteW-1:0] word_char();
      logic [qws_pkg::ByteW-1:0] c;
      c = qws_pkg::ByteW'($urandom_range(0, 255));
      if (c == qws_pkg::ChSpace || c == qws_pkg::ChTab || c == qws_pkg::ChSemi ||
          c == qws_pkg::ChDquote || c == qws_pkg::ChBslash)
         c = 8'h61;
      return c;
   endfunction

   // Build one command line from random tokens; the last byte ends the line
   task automatic add_line(bit drain_first);
      logic [qws_pkg::ByteW-1:0] chars[$];
      int tokens;
      tokens = $urandom_range(1, 6);
      repeat (tokens) begin
         case ($urandom_range(0, 9))
            0, 1, 2: repeat ($urandom_range(1, 5)) chars.push_back(word_char());
            3: repeat ($urandom_range(1, 3))
                  chars.push_back($urandom_range(0, 1) ? qws_pkg::ChSpace : qws_pkg::ChTab);
            4, 5: begin
               chars.push_back(qws_pkg::ChDquote);
               repeat ($urandom_range(0, 4)) chars.push_back(any_char());
               if ($urandom_range(0, 9) != 0) chars.push_back(qws_pkg::ChDquote);
            end
            6: begin
               chars.push_back(qws_pkg::ChBslash);
               chars.push_back(any_char());
            end
            7: chars.push_back(qws_pkg::ChSemi);
            8: chars.push_back(any_char());
            default: begin
               chars.push_back(qws_pkg::ChDquote);
               chars.push_back(qws_pkg::ChDquote);
            end
         endcase
      end
      // trailing backslash now and then
      if ($urandom_range(0, 9) == 0) chars.push_back(qws_pkg::ChBslash);
      foreach (chars[i])
         add_byte(chars[i], i == chars.size() - 1, drain_first && i == 0);
   endtask

   function automatic int pick_gap();
      if (bytes_sent >= 200 && bytes_sent < 260) return 0;
      case ($urandom_range(0, 19))
         0: return $urandom_range(10, 30);
         1, 2, 3, 4, 5: return $urandom_range(1, 3);
         default: return 0;
      endcase
   endfunction

   function automatic int pick_stall();
      if (results_seen >= 220 && results_seen < 300) return 0;
      case ($urandom_range(0, 19))
         0: return $urandom_range(8, 40);
         1, 2, 3, 4, 5: return $urandom_range(1, 3);
         default: return 0;
      endcase
   endfunction

   // Driver: predict on each req transfer, then offer the next byte or idle
   always @(posedge clock) begin
      line_byte_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            split_byte(req_tdata, req_tlast);
            bytes_sent++;
         end
         if (req_tvalid && !req_tready) begin
            // hold the offered byte
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (line_bytes.size() != 0 &&
                      !(line_bytes[0].drain && expected_rsp.size() != 0)) begin
            b = line_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= b.ch;
            req_tlast  <= b.eol;
            gap_left = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   task automatic check_result();
      qws_pkg::rsp_item_type want;
      if (expected_rsp.size() == 0) begin
         $error("unexpected result: kind %0d byte_out %h last %b",
                rsp_tuser, rsp_tdata, rsp_tlast);
         errors++;
         return;
      end
      want = expected_rsp.pop_front();
      if (rsp_tuser !== want.kind) begin
         $error("kind: expected %0d, actual %0d", want.kind, rsp_tuser);
         errors++;
      end
      if (rsp_tdata !== want.data) begin
         $error("byte_out: expected %h, actual %h", want.data, rsp_tdata);
         errors++;
      end
      if (rsp_tlast !== want.last) begin
         $error("last: expected %b, actual %b", want.last, rsp_tlast);
         errors++;
      end
   endtask

   // Monitor: check each rsp transfer, then pick the next ready level
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
            results_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= 150) begin
            // long back-pressure so the result queue fills and req stalls
            hold_done = 1'b1;
            hold_left = 80;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = pick_stall();
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      // directed: blanks, quoting, escapes, semicolons and line-end cases
      add_byte(qws_pkg::ChSpace, 1'b0);
      add_byte(qws_pkg::ChTab, 1'b0);
      add_byte(8'h61, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(qws_pkg::ChSpace, 1'b0);
      add_byte(qws_pkg::ChDquote, 1'b0);
      add_byte(qws_pkg::ChSpace, 1'b0);
      add_byte(qws_pkg::ChSemi, 1'b0);
      add_byte(qws_pkg::ChDquote, 1'b0);
      add_byte(qws_pkg::ChSemi, 1'b0);
      add_byte(qws_pkg::ChDquote, 1'b0);
      add_byte(qws_pkg::ChDquote, 1'b0);
      add_byte(qws_pkg::ChTab, 1'b0);
      add_byte(qws_pkg::ChBslash, 1'b0);
      add_byte(qws_pkg::ChSemi, 1'b0);
      add_byte(qws_pkg::ChBslash, 1'b1);
      add_byte(qws_pkg::ChDquote, 1'b0);
      add_byte(8'h78, 1'b1);
      add_byte(qws_pkg::ChSemi, 1'b1);
      add_byte(8'h7A, 1'b0);
      add_byte(qws_pkg::ChSemi, 1'b1);
      add_byte(8'h00, 1'b1);
      add_byte(qws_pkg::ChBslash, 1'b0);
      add_byte(qws_pkg::ChBslash, 1'b1);

      // random: mostly well-formed lines, some loose noise bytes
      add_line(1'b1);
      while (line_bytes.size() < 330) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4))
               add_byte(qws_pkg::ByteW'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end else begin
            add_line(line_bytes.size() > 240 && line_bytes.size() < 250);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (line_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("quoted_word_splitter verification clean");
      end else begin
         $display("quoted_word_splitter verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #3_000_000;
      $display("quoted_word_splitter verification failed");
      $finish;
   end

endmodule

// File: files.f
rtl/core/qws_pkg.sv
rtl/core/qws_decode.sv
rtl/core/qws_rsp_queue.sv
rtl/core/quoted_word_splitter.sv
tb/quoted_word_splitter_tb.sv
